// File: src/comf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// comf_pkg: shared types and constants of the center-of-mass frame shift
// Widths of the particle fields, the running totals and the divider status.
// ----------------------------------------------------------------------------
package comf_pkg;

   localparam int NUM_COMP = 6;                 // three position, three velocity
   localparam int COMP_W   = 32;                // signed Q16.16 component
   localparam int MASS_W   = 16;                // unsigned Q0.16 mass
   localparam int SUM_W    = 64;                // weighted sum, Q32.32
   localparam int TOTAL_W  = 32;                // total mass, Q16.16
   localparam int PROD_W   = 48;                // mass * component fits 48 bits
   localparam int IDX_W    = $clog2(NUM_COMP + 1);
   localparam int STEP_W   = $clog2(SUM_W);     // divider step counter

   localparam logic [COMP_W-1:0] SAT_MAX_C = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic [COMP_W-1:0] SAT_MIN_C = {1'b1, {(COMP_W-1){1'b0}}};

   typedef logic [IDX_W-1:0] idx_type;

   // status returned by the divider to the sequencer
   typedef struct packed {
      logic              done;
      logic [COMP_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: src/comf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// comf_div: iterative signed divider for the center values
// Restoring division, one quotient bit per cycle, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module comf_div
   import comf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   dividend,
   input  wire logic [TOTAL_W-1:0] divisor,
   output div_rsp_type             rsp
);

   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [TOTAL_W-1:0] dvs_ff, dvs_in;
   logic [COMP_W-1:0]  res_ff, res_in;

   logic [TOTAL_W:0]   shifted;
   logic [TOTAL_W:0]   trial;
   logic               fits;
   logic               too_big;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign too_big = |quo_ff[SUM_W-1:COMP_W-1];

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      res_in  = res_ff;
      if (start) begin
         // take the magnitude, keep the sign for the end
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? trial[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end else if (fin_ff) begin
         // restore the sign and clip to 32 bits
         if (neg_ff) begin
            res_in = too_big ? SAT_MIN_C : (~quo_ff[COMP_W-1:0] + COMP_W'(1));
         end else begin
            res_in = too_big ? SAT_MAX_C : quo_ff[COMP_W-1:0];
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      res_ff  <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = res_ff;

endmodule
`default_nettype wire

// File: src/center_of_mass_frame_shift.sv
`default_nettype none
// ----------------------------------------------------------------------------
// center_of_mass_frame_shift: move a particle set into its center-of-mass frame
// Two passes: accumulate mass-weighted sums, then subtract center and mean
// velocity from every particle, saturating to signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one particle per transaction. req_mode 0 accumulates it
//    (no response), req_mode 1 corrects it (one response on rsp_*).
//  - req_stall is high while a transaction is in work; one particle at a time.
//  - Accumulate: one shared 17x32 multiplier and one 64-bit adder walk the six
//    components, multiply and add overlapped.
//  - Correct, center known: one shared 33-bit subtract-and-clip unit walks the
//    six components.
//  - With a nonzero total, the first correct particle of a pass first runs the
//    shared divider six times; each run is start, 64 quotient bits, sign and
//    clip, hand-over.
//  - The response sits in an output register; the next particle is taken
//    while it waits. A finished correction holds while that register is full
//    and rsp_stall is high.
//  - Reset (synchronous) clears the totals, the centers and all valid flags.
//  - An accumulate particle after a correction pass clears the totals first.
// ----------------------------------------------------------------------------
module center_of_mass_frame_shift
   import comf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // particle transactions
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic [MASS_W-1:0]        req_mass,
   input  wire logic signed [COMP_W-1:0] req_pos_x,
   input  wire logic signed [COMP_W-1:0] req_pos_y,
   input  wire logic signed [COMP_W-1:0] req_pos_z,
   input  wire logic signed [COMP_W-1:0] req_vel_x,
   input  wire logic signed [COMP_W-1:0] req_vel_y,
   input  wire logic signed [COMP_W-1:0] req_vel_z,
   // corrected particle transactions
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [COMP_W-1:0]      rsp_out_pos_x,
   output logic signed [COMP_W-1:0]      rsp_out_pos_y,
   output logic signed [COMP_W-1:0]      rsp_out_pos_z,
   output logic signed [COMP_W-1:0]      rsp_out_vel_x,
   output logic signed [COMP_W-1:0]      rsp_out_vel_y,
   output logic signed [COMP_W-1:0]      rsp_out_vel_z,
   output logic                          rsp_zero_mass,
   output logic                          rsp_saturated
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_SUB,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // pass state
   logic [SUM_W-1:0]   sums_ff   [NUM_COMP];
   logic [SUM_W-1:0]   sums_in   [NUM_COMP];
   logic [COMP_W-1:0]  center_ff [NUM_COMP];
   logic [COMP_W-1:0]  center_in [NUM_COMP];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               ready_ff, ready_in;

   // working registers of the current particle
   logic [COMP_W-1:0]  comp_ff   [NUM_COMP];
   logic [COMP_W-1:0]  comp_in   [NUM_COMP];
   logic [COMP_W-1:0]  res_ff    [NUM_COMP];
   logic [COMP_W-1:0]  res_in    [NUM_COMP];
   logic [MASS_W-1:0]  mass_ff, mass_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   idx_type            cnt_ff, cnt_in;
   logic               clip_ff, clip_in;
   logic               div_start_ff, div_start_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COMP_W-1:0]  rsp_res_ff [NUM_COMP];
   logic [COMP_W-1:0]  rsp_res_in [NUM_COMP];
   logic               rsp_zero_ff, rsp_zero_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // shared datapath
   logic               cnt_valid;
   logic [COMP_W-1:0]  comp_sel;
   logic [COMP_W-1:0]  center_sel;
   logic [SUM_W-1:0]   sum_sel;
   logic signed [MASS_W+COMP_W:0] mult_full;
   logic [COMP_W:0]    diff;
   logic               diff_ovf;
   logic [COMP_W-1:0]  diff_sat;
   idx_type            add_idx;
   div_rsp_type        div_rsp;

   assign cnt_valid  = cnt_ff < IDX_W'(NUM_COMP);
   assign comp_sel   = cnt_valid ? comp_ff[cnt_ff]   : '0;
   assign center_sel = cnt_valid ? center_ff[cnt_ff] : '0;
   assign sum_sel    = cnt_valid ? sums_ff[cnt_ff]   : '0;
   assign add_idx    = cnt_ff - IDX_W'(1);

   // shared multiplier: unsigned mass times signed component
   assign mult_full = $signed({1'b0, mass_ff}) * $signed(comp_sel);

   // shared subtract-and-clip unit
   assign diff     = {comp_sel[COMP_W-1], comp_sel} - {center_sel[COMP_W-1], center_sel};
   assign diff_ovf = diff[COMP_W] != diff[COMP_W-1];
   assign diff_sat = diff_ovf ? (diff[COMP_W] ? SAT_MIN_C : SAT_MAX_C) : diff[COMP_W-1:0];

   comf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_sel),
      .divisor  (total_ff),
      .rsp      (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      sums_in      = sums_ff;
      center_in    = center_ff;
      total_in     = total_ff;
      ready_in     = ready_ff;
      comp_in      = comp_ff;
      res_in       = res_ff;
      mass_in      = mass_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      clip_in      = clip_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_sat_in   = rsp_sat_ff;

      // drop the response once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               comp_in[0] = req_pos_x;
               comp_in[1] = req_pos_y;
               comp_in[2] = req_pos_z;
               comp_in[3] = req_vel_x;
               comp_in[4] = req_vel_y;
               comp_in[5] = req_vel_z;
               mass_in    = req_mass;
               cnt_in     = '0;
               clip_in    = 1'b0;
               if (!req_mode) begin
                  // a new pass starts from clean totals
                  if (ready_ff) begin
                     for (int i = 0; i < NUM_COMP; i++) begin
                        sums_in[i]   = '0;
                        center_in[i] = '0;
                     end
                     ready_in = 1'b0;
                     total_in = TOTAL_W'(req_mass);
                  end else begin
                     total_in = total_ff + TOTAL_W'(req_mass);
                  end
                  state_in = ST_ACC;
               end else if (ready_ff) begin
                  state_in = ST_SUB;
               end else if (total_ff == '0) begin
                  // centers are still zero: pass the values through
                  ready_in = 1'b1;
                  state_in = ST_SUB;
               end else begin
                  div_start_in = 1'b1;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_ACC: begin
            // multiply component cnt while adding product of cnt-1
            if (cnt_valid) begin
               prod_in = mult_full[PROD_W-1:0];
            end
            if (cnt_ff != '0) begin
               sums_in[add_idx] = sums_ff[add_idx]
                  + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            end
            if (cnt_valid) begin
               cnt_in = cnt_ff + IDX_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               center_in[cnt_ff] = div_rsp.quot;
               if (cnt_ff == IDX_W'(NUM_COMP - 1)) begin
                  ready_in = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_SUB;
               end else begin
                  cnt_in       = cnt_ff + IDX_W'(1);
                  div_start_in = 1'b1;
               end
            end
         end
         ST_SUB: begin
            res_in[cnt_ff] = diff_sat;
            clip_in        = clip_ff | diff_ovf;
            if (cnt_ff == IDX_W'(NUM_COMP - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_res_in   = res_ff;
               rsp_zero_in  = total_ff == '0;
               rsp_sat_in   = clip_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      comp_ff    <= comp_in;
      res_ff     <= res_in;
      mass_ff    <= mass_in;
      prod_ff    <= prod_in;
      cnt_ff     <= cnt_in;
      clip_ff    <= clip_in;
      rsp_res_ff <= rsp_res_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_sat_ff <= rsp_sat_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         ready_ff     <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COMP; i++) begin
            sums_ff[i]   <= '0;
            center_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ready_ff     <= ready_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff      <= sums_in;
         center_ff    <= center_in;
      end
   end

   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pos_x = rsp_res_ff[0];
   assign rsp_out_pos_y = rsp_res_ff[1];
   assign rsp_out_pos_z = rsp_res_ff[2];
   assign rsp_out_vel_x = rsp_res_ff[3];
   assign rsp_out_vel_y = rsp_res_ff[4];
   assign rsp_out_vel_z = rsp_res_ff[5];
   assign rsp_zero_mass = rsp_zero_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef ASSERT_OFF
   // the divider only runs on a nonzero total mass
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> total_ff != '0)
      else $error("divider started with zero total mass");

   // centers stay zero until the pass starts computing them
   a_center_clear: assert property (@(posedge clock) disable iff (reset)
      (!ready_ff && state_ff != ST_DIV)
         |-> (center_ff[0] | center_ff[1] | center_ff[2]
              | center_ff[3] | center_ff[4] | center_ff[5]) == '0)
      else $error("center value set without center ready");

   // a response appears only after a finished correction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside of completion");

   // the divider reports only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider result with no division pending");
`endif

endmodule
`default_nettype wire

// File: bench/center_of_mass_frame_shift_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_of_mass_frame_shift_tb: self-checking bench for the frame shift block
// Drive particle passes (accumulate, then correct) with random gaps on both
// channels. Track the weighted sums, the total mass and the center in a
// shadow predictor. Compare every corrected particle field by field against
// the oldest expected one.
// ----------------------------------------------------------------------------
module center_of_mass_frame_shift_tb;
   import comf_pkg::*;

   localparam logic MODE_ACCUMULATE = 1'b0;
   localparam logic MODE_CORRECT    = 1'b1;

   localparam logic [MASS_W-1:0] MASS_FULL = {MASS_W{1'b1}};

   localparam longint COMP_HI = 64'sd2147483647;
   localparam longint COMP_LO = -64'sd2147483648;

   localparam int RANDOM_ITEMS = 1200;
   localparam int IDLE_PCT     = 30;
   localparam int DRAIN_CYCLES = 500;     // first correction runs the divider

   // component order on both channels: pos x/y/z, then vel x/y/z
   typedef struct packed {
      logic                            mode;
      logic [MASS_W-1:0]               mass;
      logic [NUM_COMP-1:0][COMP_W-1:0] comp;
   } particle_type;

   typedef struct packed {
      logic [NUM_COMP-1:0][COMP_W-1:0] comp;
      logic                            zero_mass;
      logic                            saturated;
   } shifted_type;

   // -------------------------------------------------------------------------
   // Shadow of the running totals and the center; queue of corrected particles
   // still owed by the block.
   // -------------------------------------------------------------------------
   class com_frame_tracker;
      bit [SUM_W-1:0]   weighted [NUM_COMP];
      bit [TOTAL_W-1:0] mass_total;
      bit [COMP_W-1:0]  center [NUM_COMP];
      bit               center_known;
      shifted_type      shifted_due[$];
      int               mismatches;
      string            comp_name [NUM_COMP] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                                                 "out_vel_x", "out_vel_y", "out_vel_z"};

      function new();
         clear_totals();
         mismatches = 0;
      endfunction

      function void clear_totals();
         foreach (weighted[i]) begin
            weighted[i] = '0;
            center[i]   = '0;
         end
         mass_total   = '0;
         center_known = 1'b0;
      endfunction

      function void note_particle(particle_type p);
         longint         prod;
         longint         diff;
         bit [SUM_W-1:0] mag;
         bit [SUM_W-1:0] quot;
         shifted_type    s;
         if (p.mode == MODE_ACCUMULATE) begin
            if (center_known) clear_totals();
            for (int i = 0; i < NUM_COMP; i++) begin
               prod = $signed({1'b0, p.mass}) * $signed(p.comp[i]);
               weighted[i] += prod;
            end
            mass_total += p.mass;
            return;
         end
         // divide once per pass, truncating toward zero and clipping to 32 bits
         if (!center_known) begin
            for (int i = 0; i < NUM_COMP; i++) begin
               if (mass_total == 0) begin
                  center[i] = '0;
               end else begin
                  mag  = weighted[i][SUM_W-1] ? -weighted[i] : weighted[i];
                  quot = mag / {{(SUM_W-TOTAL_W){1'b0}}, mass_total};
                  if (weighted[i][SUM_W-1])
                     center[i] = (quot >= 64'h8000_0000) ? SAT_MIN_C : -quot[COMP_W-1:0];
                  else
                     center[i] = (quot > 64'h7FFF_FFFF) ? SAT_MAX_C : quot[COMP_W-1:0];
               end
            end
            center_known = 1'b1;
         end
         s.saturated = 1'b0;
         for (int i = 0; i < NUM_COMP; i++) begin
            diff = longint'($signed(p.comp[i])) - longint'($signed(center[i]));
            if (diff > COMP_HI) begin
               s.comp[i]   = SAT_MAX_C;
               s.saturated = 1'b1;
            end else if (diff < COMP_LO) begin
               s.comp[i]   = SAT_MIN_C;
               s.saturated = 1'b1;
            end else begin
               s.comp[i] = diff[COMP_W-1:0];
            end
         end
         s.zero_mass = (mass_total == 0);
         shifted_due.push_back(s);
      endfunction

      function void check_shifted(shifted_type got);
         shifted_type want;
         if (shifted_due.size() == 0) begin
            $error("corrected particle arrived with none outstanding");
            mismatches++;
            return;
         end
         want = shifted_due.pop_front();
         for (int i = 0; i < NUM_COMP; i++) begin
            if (got.comp[i] !== want.comp[i]) begin
               $error("%s: expected %0d, got %0d", comp_name[i],
                      $signed(want.comp[i]), $signed(got.comp[i]));
               mismatches++;
            end
         end
         if (got.zero_mass !== want.zero_mass) begin
            $error("zero_mass: expected %0b, got %0b", want.zero_mass, got.zero_mass);
            mismatches++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block hookup; every input starts at a known value.
   // -------------------------------------------------------------------------
   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode  = MODE_ACCUMULATE;
   logic [MASS_W-1:0]        req_mass  = '0;
   logic signed [COMP_W-1:0] req_pos_x = '0;
   logic signed [COMP_W-1:0] req_pos_y = '0;
   logic signed [COMP_W-1:0] req_pos_z = '0;
   logic signed [COMP_W-1:0] req_vel_x = '0;
   logic signed [COMP_W-1:0] req_vel_y = '0;
   logic signed [COMP_W-1:0] req_vel_z = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [COMP_W-1:0] rsp_out_pos_x;
   logic signed [COMP_W-1:0] rsp_out_pos_y;
   logic signed [COMP_W-1:0] rsp_out_pos_z;
   logic signed [COMP_W-1:0] rsp_out_vel_x;
   logic signed [COMP_W-1:0] rsp_out_vel_y;
   logic signed [COMP_W-1:0] rsp_out_vel_z;
   logic                     rsp_zero_mass;
   logic                     rsp_saturated;

   // calm: suspend idling on both channels for a stretch
   bit               calm = 1'b0;
   com_frame_tracker frames = new();

   center_of_mass_frame_shift uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_mass      (req_mass),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_vel_z     (req_vel_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_pos_x (rsp_out_pos_x),
      .rsp_out_pos_y (rsp_out_pos_y),
      .rsp_out_pos_z (rsp_out_pos_z),
      .rsp_out_vel_x (rsp_out_vel_x),
      .rsp_out_vel_y (rsp_out_vel_y),
      .rsp_out_vel_z (rsp_out_vel_z),
      .rsp_zero_mass (rsp_zero_mass),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // end the run if the block hangs; a full run takes a few ms at most
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: stall at random, check each transaction taken at this edge.
   // rsp_stall read here is still the value the block saw at the edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (!reset && rsp_valid && !rsp_stall)
         frames.check_shifted({rsp_out_vel_z, rsp_out_vel_y, rsp_out_vel_x,
                               rsp_out_pos_z, rsp_out_pos_y, rsp_out_pos_x,
                               rsp_zero_mass, rsp_saturated});
   end

   // -------------------------------------------------------------------------
   // Particle side
   // -------------------------------------------------------------------------
   function automatic particle_type particle_of(logic mode, logic [MASS_W-1:0] mass,
                                                logic [COMP_W-1:0] px, logic [COMP_W-1:0] py,
                                                logic [COMP_W-1:0] pz, logic [COMP_W-1:0] vx,
                                                logic [COMP_W-1:0] vy, logic [COMP_W-1:0] vz);
      particle_type p;
      p.mode    = mode;
      p.mass    = mass;
      p.comp[0] = px;
      p.comp[1] = py;
      p.comp[2] = pz;
      p.comp[3] = vx;
      p.comp[4] = vy;
      p.comp[5] = vz;
      return p;
   endfunction

   // mostly full-range values, with the extremes and small magnitudes mixed in
   function automatic particle_type random_particle(logic mode);
      particle_type p;
      logic [31:0]  r;
      p.mode = mode;
      case ($urandom_range(9))
         0:       p.mass = '0;
         1:       p.mass = MASS_FULL;
         2:       p.mass = MASS_W'($urandom_range(16, 1));
         default: p.mass = MASS_W'($urandom);
      endcase
      for (int i = 0; i < NUM_COMP; i++) begin
         r = $urandom;
         case ($urandom_range(9))
            0:       p.comp[i] = SAT_MAX_C;
            1:       p.comp[i] = SAT_MIN_C;
            2, 3:    p.comp[i] = {{12{r[19]}}, r[19:0]};
            default: p.comp[i] = r;
         endcase
      end
      return p;
   endfunction

   // present one particle, hold it until taken, then book it in the tracker;
   // valid stays high so back-to-back transactions need no extra edge
   task automatic send_particle(particle_type p);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= p.mode;
      req_mass  <= p.mass;
      req_pos_x <= p.comp[0];
      req_pos_y <= p.comp[1];
      req_pos_z <= p.comp[2];
      req_vel_x <= p.comp[3];
      req_vel_y <= p.comp[4];
      req_vel_z <= p.comp[5];
      do @(posedge clock); while (req_stall);
      frames.note_particle(p);
   endtask

   // drop valid and hold off until every correction owed has come back
   task automatic drain_corrections();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames.shifted_due.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int             sent;
      int             pass_no;
      int             n_acc;
      int             n_cor;
      logic [31:0]    r;
      sent    = 0;
      pass_no = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // correct with nothing accumulated: zero total, values pass through
      send_particle(particle_of(MODE_CORRECT, 16'h1234, SAT_MAX_C, SAT_MIN_C, 32'd0,
                                32'hFFFF_FFFF, 32'd1, 32'h8000_0001));
      send_particle(particle_of(MODE_CORRECT, MASS_FULL, SAT_MIN_C, SAT_MAX_C, 32'h0001_0000,
                                32'd0, SAT_MAX_C, SAT_MIN_C));

      // new pass: one full-mass particle at the extremes plus a massless one
      send_particle(particle_of(MODE_ACCUMULATE, MASS_FULL, SAT_MAX_C, SAT_MIN_C, SAT_MAX_C,
                                SAT_MIN_C, 32'd0, 32'd1));
      send_particle(particle_of(MODE_ACCUMULATE, 16'h0000, SAT_MIN_C, SAT_MAX_C, SAT_MIN_C,
                                SAT_MAX_C, SAT_MIN_C, SAT_MAX_C));
      // opposite extremes against that center: clip high and low
      send_particle(particle_of(MODE_CORRECT, 16'h0000, SAT_MIN_C, SAT_MAX_C, 32'd0,
                                32'd0, SAT_MIN_C, SAT_MAX_C));
      // the particle itself lands on zero
      send_particle(particle_of(MODE_CORRECT, MASS_FULL, SAT_MAX_C, SAT_MIN_C, SAT_MAX_C,
                                SAT_MIN_C, 32'd0, 32'd1));

      // mixed masses, signs that cancel, then reuse of the center
      send_particle(particle_of(MODE_ACCUMULATE, 16'h0001, 32'h0003_0000, 32'hFFFD_0000,
                                32'h7FFF_0000, 32'h8001_0000, 32'h0000_8000, 32'hFFFF_8000));
      send_particle(particle_of(MODE_ACCUMULATE, MASS_FULL, 32'hFFFF_FFFF, 32'h0000_0001,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000));
      send_particle(particle_of(MODE_ACCUMULATE, 16'h8000, 32'h1234_5678, 32'hEDCB_A988,
                                32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA));
      repeat (3) send_particle(random_particle(MODE_CORRECT));

      // a pass whose particles all weigh nothing
      repeat (2) send_particle(particle_of(MODE_ACCUMULATE, 16'h0000, SAT_MAX_C, SAT_MAX_C,
                                           SAT_MIN_C, SAT_MIN_C, 32'h1, 32'hFFFF_FFFF));
      repeat (2) send_particle(random_particle(MODE_CORRECT));
      drain_corrections();

      // random passes: mostly accumulate-then-correct, some noise and odd passes
      while (sent < RANDOM_ITEMS) begin
         calm = (pass_no >= 40 && pass_no < 52);
         case ($urandom_range(99)) inside
            [0:79]: begin
               n_acc = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
               n_cor = $urandom_range(12, 1);
               repeat (n_acc) send_particle(random_particle(MODE_ACCUMULATE));
               repeat (n_cor) send_particle(random_particle(MODE_CORRECT));
               sent += n_acc + n_cor;
            end
            [80:89]: begin
               n_acc = $urandom_range(10, 1);
               repeat (n_acc) send_particle(random_particle(logic'($urandom_range(1))));
               sent += n_acc;
            end
            default: begin
               // accumulate only massless particles, or none at all
               n_acc = $urandom_range(3);
               n_cor = $urandom_range(4, 1);
               repeat (n_acc) begin
                  r = $urandom;
                  send_particle(particle_of(MODE_ACCUMULATE, 16'h0000, r, ~r, $urandom,
                                           $urandom, $urandom, $urandom));
               end
               repeat (n_cor) send_particle(random_particle(MODE_CORRECT));
               sent += n_acc + n_cor;
            end
         endcase
         if (pass_no % 8 == 7) drain_corrections();
         pass_no++;
      end
      calm = 1'b0;
      drain_corrections();

      repeat (4) send_particle(random_particle(MODE_CORRECT));

      // let the last corrections and any accumulate still in work finish
      drain_corrections();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
